// File: hdl/rlsc_pkg.sv
// ----------------------------------------------------------------------------
// rlsc_pkg
// Shared types, constants and rounding helpers for the RGB luma scaler.
// ----------------------------------------------------------------------------
package rlsc_pkg;

  // Number of register stages from input word to output word.
  localparam int unsigned NumStages = 5;

  // Luma gain after reset: unity in unsigned Q4.12.
  localparam logic [15:0] GainReset = 16'd4096;

  // Luma weights, unsigned Q0.14.
  localparam logic [13:0] CoefYr = 14'd4899;
  localparam logic [13:0] CoefYg = 14'd9617;
  localparam logic [13:0] CoefYb = 14'd1868;

  // Chroma and inverse transform weights, Q2.14 held as signed operands.
  localparam logic signed [31:0] CoefU  = 32'sd8061;
  localparam logic signed [31:0] CoefV  = 32'sd14369;
  localparam logic signed [31:0] CoefRv = 32'sd18675;
  localparam logic signed [31:0] CoefGu = 32'sd6466;
  localparam logic signed [31:0] CoefGv = 32'sd9513;
  localparam logic signed [31:0] CoefBu = 32'sd33294;

  // Input pixel word.
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pixel_in_t;

  // Output pixel word.
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pixel_out_t;

  // Chroma with 8 fraction bits, scaled luma with 8 fraction bits, and alpha.
  typedef struct packed {
    logic signed [16:0] u;
    logic signed [16:0] v;
    logic [19:0]        ys;
    logic [7:0]         alpha;
  } yuv_t;

  // Load enables of the forward transform stages.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } fwd_ctrl_t;

  // Load enables of the inverse transform stages.
  typedef struct packed {
    logic en4;
    logic en5;
  } inv_ctrl_t;

  // Divide a signed product by 2^14, rounding half away from zero.
  function automatic logic signed [16:0] round_q14(input logic signed [31:0] x);
    logic [31:0] mag;
    logic [31:0] rnd;
    mag = x[31] ? 32'(-x) : 32'(x);
    rnd = (mag + 32'd8192) >> 14;
    if (x[31]) begin
      round_q14 = -$signed(rnd[16:0]);
    end else begin
      round_q14 = $signed(rnd[16:0]);
    end
  endfunction

  // Divide by 2^22 half away from zero and saturate to 0..255. Any negative
  // value rounds to zero or below, so it always saturates to zero.
  function automatic logic [7:0] round_sat_q22(input logic signed [35:0] x);
    logic [35:0] rnd;
    rnd = (36'(x) + 36'd2097152) >> 22;
    if (x[35]) begin
      round_sat_q22 = 8'd0;
    end else if (rnd > 36'd255) begin
      round_sat_q22 = 8'hFF;
    end else begin
      round_sat_q22 = rnd[7:0];
    end
  endfunction

endpackage

// File: hdl/rlsc_fwd.sv
// ----------------------------------------------------------------------------
// rlsc_fwd
// Forward transform: RGB to Y, U, V and the gain on Y, in three stages.
// ----------------------------------------------------------------------------
module rlsc_fwd import rlsc_pkg::*; (
  input  logic      clk_i,
  input  fwd_ctrl_t ctrl_i,
  input  pixel_in_t pix_i,
  input  logic [15:0] gain_i,
  output yuv_t      yuv_o
);

  // Stage 1: weighted luma sum, rounded to 8 fraction bits.
  logic [21:0] ysum;
  logic [15:0] y_d, y_q;
  logic [7:0]  r1_q, b1_q, a1_q;

  always_comb begin
    ysum = 22'(22'(pix_i.red_in) * 22'(CoefYr) + 22'(pix_i.green_in) * 22'(CoefYg)
              + 22'(pix_i.blue_in) * 22'(CoefYb) + 22'd32);
    y_d  = ysum[21:6];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      y_q  <= y_d;
      r1_q <= pix_i.red_in;
      b1_q <= pix_i.blue_in;
      a1_q <= pix_i.alpha_in;
    end
  end

  // Stage 2: chroma products and the luma gain product.
  logic signed [17:0] diff_b, diff_r;
  logic signed [31:0] pu_d, pv_d, pu_q, pv_q;
  logic [31:0]        py_d, py_q;
  logic [7:0]         a2_q;

  always_comb begin
    diff_b = $signed({2'b00, b1_q, 8'h00}) - $signed({2'b00, y_q});
    diff_r = $signed({2'b00, r1_q, 8'h00}) - $signed({2'b00, y_q});
    pu_d   = 32'(diff_b) * CoefU;
    pv_d   = 32'(diff_r) * CoefV;
    py_d   = 32'(y_q) * 32'(gain_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      pu_q <= pu_d;
      pv_q <= pv_d;
      py_q <= py_d;
      a2_q <= a1_q;
    end
  end

  // Stage 3: round the products back to 8 fraction bits.
  yuv_t        yuv_d, yuv_q;
  logic [31:0] py_rnd;

  always_comb begin
    py_rnd      = py_q + 32'd2048;
    yuv_d.u     = round_q14(pu_q);
    yuv_d.v     = round_q14(pv_q);
    yuv_d.ys    = py_rnd[31:12];
    yuv_d.alpha = a2_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en3) begin
      yuv_q <= yuv_d;
    end
  end

  assign yuv_o = yuv_q;

endmodule

// File: hdl/rlsc_inv.sv
// ----------------------------------------------------------------------------
// rlsc_inv
// Inverse transform: Y, U, V back to RGB, rounded and saturated, two stages.
// ----------------------------------------------------------------------------
module rlsc_inv import rlsc_pkg::*; (
  input  logic       clk_i,
  input  inv_ctrl_t  ctrl_i,
  input  yuv_t       yuv_i,
  output pixel_out_t pix_o
);

  // Stage 4: chroma contributions to each channel.
  logic signed [31:0] rv_q, gu_q, gv_q, bu_q;
  logic [19:0]        ys4_q;
  logic [7:0]         a4_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en4) begin
      rv_q  <= 32'(yuv_i.v) * CoefRv;
      gu_q  <= 32'(yuv_i.u) * CoefGu;
      gv_q  <= 32'(yuv_i.v) * CoefGv;
      bu_q  <= 32'(yuv_i.u) * CoefBu;
      ys4_q <= yuv_i.ys;
      a4_q  <= yuv_i.alpha;
    end
  end

  // Stage 5: accumulate with 22 fraction bits, round once and saturate.
  logic signed [35:0] base, r_acc, g_acc, b_acc;
  pixel_out_t         pix_d, pix_q;

  always_comb begin
    base            = $signed({2'b00, ys4_q, 14'd0});
    r_acc           = base + 36'(rv_q);
    g_acc           = base - 36'(gu_q) - 36'(gv_q);
    b_acc           = base + 36'(bu_q);
    pix_d.red_out   = round_sat_q22(r_acc);
    pix_d.green_out = round_sat_q22(g_acc);
    pix_d.blue_out  = round_sat_q22(b_acc);
    pix_d.alpha_out = a4_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en5) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// File: hdl/rgb_luminance_scaler_core.sv
// ----------------------------------------------------------------------------
// rgb_luminance_scaler_core
// Luma gain on an RGBA pixel stream through a BT.601 YUV round trip.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock while the output side is ready
// and returns one pixel word for each, in order. The five register stages
// are luma sum, chroma and gain multiplies, rounding, inverse multiplies,
// and accumulate with saturation; each stage has its own valid bit and holds
// when it is full and the stage after it cannot move, so empty slots close
// up and a stalled output still lets new words enter until the pipe is
// full. The gain register is written through the configuration channel, which
// is always ready; write it only while no pixel is in flight.
module rgb_luminance_scaler_core import rlsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pixel_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pixel_out_t  out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // Gain register.
  logic [15:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  // Stage valid bits; a stage loads when it is empty or its successor moves.
  logic [NumStages-1:0] vld_d, vld_q, en;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];

  // Datapath.
  fwd_ctrl_t fwd_ctrl;
  inv_ctrl_t inv_ctrl;
  yuv_t      yuv;

  always_comb begin
    fwd_ctrl.en1 = en[0];
    fwd_ctrl.en2 = en[1];
    fwd_ctrl.en3 = en[2];
    inv_ctrl.en4 = en[3];
    inv_ctrl.en5 = en[4];
  end

  rlsc_fwd u_fwd (
    .clk_i  (clk_i),
    .ctrl_i (fwd_ctrl),
    .pix_i  (in_data_i),
    .gain_i (gain_q),
    .yuv_o  (yuv)
  );

  rlsc_inv u_inv (
    .clk_i  (clk_i),
    .ctrl_i (inv_ctrl),
    .yuv_i  (yuv),
    .pix_o  (out_data_o)
  );

endmodule

// File: hdl/rlsc_checker.sv
// ----------------------------------------------------------------------------
// rlsc_checker
// Port-level checks of the luma scaler's flow control, bound to the top level.
// ----------------------------------------------------------------------------
module rlsc_checker import rlsc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input pixel_out_t  out_data_o
);

  // Words accepted but not yet delivered.
  logic [3:0] occ_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // No word is shown that was not accepted, and the pipe never overfills.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != 4'd0)
    else $error("output word without a pending input");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(NumStages))
    else $error("more words in flight than stages");

  // Input backs up only behind a stalled output word.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without an output stall");

  // With the output free, an accepted word appears after the pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i |=> out_valid_o)
    else $error("accepted word did not arrive in time");

endmodule

bind rgb_luminance_scaler_core rlsc_checker u_rlsc_checker (.*);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB luma scaler core.
// ----------------------------------------------------------------------------
// Pixel words go in through the valid/ready input channel, and each output
// word is checked field by field against a bit-exact fixed-point
// prediction of the YUV round trip at the luma gain in force when the word
// was accepted. The gain is written only while the pipe is empty. Both sides
// idle at random, with one long stretch at full rate. A directed pass covers
// the channel extremes, the primaries, zero gain and the largest gain.
// Random streams then run under a series of gain settings.
// ----------------------------------------------------------------------------
module tb;
  import rlsc_pkg::*;

  localparam int unsigned IdlePct       = 8;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = NumStages + 4;
  localparam int unsigned PhaseItems    = 190;
  localparam logic [15:0] GainMax       = 16'hFFFF;
  localparam logic [15:0] GainZero      = 16'h0000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  pixel_in_t   in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pixel_out_t  out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  // Luma gain as the block holds it, and the words still to come out.
  logic [15:0] gain_setting = GainReset;
  pixel_out_t  pending_pixels[$];

  int unsigned send_idle_pct  = IdlePct;
  int unsigned sink_stall_pct = IdlePct;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  rgb_luminance_scaler_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // Divide by 2^n with the rounding of the datapath: half away from zero.
  function automatic longint round_away(input longint val, input int unsigned n);
    longint half;
    half = longint'(1) <<< (n - 1);
    if (val < 0) begin
      return -((-val + half) >>> n);
    end
    return (val + half) >>> n;
  endfunction

  function automatic logic [7:0] saturate_channel(input longint val);
    if (val < 0) begin
      return 8'd0;
    end else if (val > 255) begin
      return 8'd255;
    end
    return val[7:0];
  endfunction

  // Forward BT.601 transform, luma gain, inverse transform, all in fixed point.
  function automatic pixel_out_t predict_luma_scaled(input pixel_in_t px,
                                                     input logic [15:0] gain);
    longint r, g, b, luma, chroma_u, chroma_v, luma_scaled, base;
    pixel_out_t res;
    r = longint'(px.red_in);
    g = longint'(px.green_in);
    b = longint'(px.blue_in);
    luma        = round_away(4899 * r + 9617 * g + 1868 * b, 6);
    chroma_u    = round_away(8061 * (b * 256 - luma), 14);
    chroma_v    = round_away(14369 * (r * 256 - luma), 14);
    luma_scaled = round_away(luma * longint'(gain), 12);
    base        = luma_scaled * 16384;
    res.red_out   = saturate_channel(round_away(base + 18675 * chroma_v, 22));
    res.green_out = saturate_channel(round_away(base - 6466 * chroma_u
                                                - 9513 * chroma_v, 22));
    res.blue_out  = saturate_channel(round_away(base + 33294 * chroma_u, 22));
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  function automatic pixel_in_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [7:0] a);
    pixel_in_t px;
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    px.alpha_in = a;
    return px;
  endfunction

  // Random channel value, leaning toward the ends of the range.
  function automatic logic [7:0] rand_channel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return 8'd0;
    end else if (pick < 20) begin
      return 8'd255;
    end
    return 8'($urandom_range(255));
  endfunction

  // Offer one pixel word, after a random idle gap, and hold it until taken.
  task automatic send_pixel(input pixel_in_t px);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(predict_luma_scaled(px, gain_setting));
  endtask

  // Stop offering words and wait until every expected word has come out.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Write the luma gain once the pipe is empty.
  task automatic write_gain(input logic [15:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    gain_setting = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Black, white, primaries, secondaries and mid gray at unity gain.
  task automatic test_unity_extremes();
    write_gain(GainReset);
    send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   8'd0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(8'd255, 8'd0,   8'd0,   8'h5A));
    send_pixel(make_pixel(8'd0,   8'd255, 8'd0,   8'hA5));
    send_pixel(make_pixel(8'd0,   8'd0,   8'd255, 8'd1));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd0,   8'd128));
    send_pixel(make_pixel(8'd0,   8'd255, 8'd255, 8'd127));
    send_pixel(make_pixel(8'd255, 8'd0,   8'd255, 8'd254));
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 8'h80));
    send_pixel(make_pixel(8'd1,   8'd2,   8'd3,   8'h55));
    send_pixel(make_pixel(8'd254, 8'd1,   8'd254, 8'hAA));
  endtask

  // Zero gain leaves only chroma, so channels with negative chroma clip low;
  // the largest gain drives nearly everything into the top clip.
  task automatic test_gain_extremes();
    write_gain(GainZero);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd9));
    send_pixel(make_pixel(8'd255, 8'd0,   8'd0,   8'd10));
    send_pixel(make_pixel(8'd0,   8'd0,   8'd255, 8'd11));
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 8'd12));
    write_gain(GainMax);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd13));
    send_pixel(make_pixel(8'd16,  8'd16,  8'd16,  8'd14));
    send_pixel(make_pixel(8'd0,   8'd255, 8'd0,   8'd15));
    send_pixel(make_pixel(8'd1,   8'd1,   8'd1,   8'd16));
  endtask

  // Random pixel streams, one gain setting per phase. One phase runs with
  // neither side idling.
  task automatic test_random_stream();
    logic [15:0] gains[10];
    gains[0] = GainReset;
    gains[1] = 16'($urandom_range(8192, 2048));
    gains[2] = GainZero;
    gains[3] = GainMax;
    gains[4] = 16'($urandom_range(8192, 2048));
    gains[5] = 16'($urandom_range(65535));
    gains[6] = 16'd1;
    gains[7] = 16'($urandom_range(65535));
    gains[8] = 16'($urandom_range(4200, 3900));
    gains[9] = GainReset;
    foreach (gains[p]) begin
      write_gain(gains[p]);
      send_idle_pct  = (p == 4) ? 0 : IdlePct;
      sink_stall_pct = (p == 4) ? 0 : IdlePct;
      repeat (PhaseItems) begin
        send_pixel(make_pixel(rand_channel(), rand_channel(), rand_channel(),
                              8'($urandom_range(255))));
      end
    end
    send_idle_pct  = IdlePct;
    sink_stall_pct = IdlePct;
  endtask

  // Output side: stall at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Compare each output word with the oldest expectation.
  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: output word with none expected, expected none, actual %p",
                 $time, out_data);
        mismatch_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        check_field("red",   exp_px.red_out,   out_data.red_out);
        check_field("green", exp_px.green_out, out_data.green_out);
        check_field("blue",  exp_px.blue_out,  out_data.blue_out);
        check_field("alpha", exp_px.alpha_out, out_data.alpha_out);
      end
    end
  end

  // Watchdog: end the run when no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_unity_extremes();
    test_gain_extremes();
    test_random_stream();

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
